FILE: rtl/bitmap_frame_allocator_assert.svh
// assertion macros used by the checker file bfa_checker.sv
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define BFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off while reset is low
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bfa_pkg.sv
package bfa_pkg;

	localparam int MAX_FRAMES = 4096;
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int BIT_AW     = $clog2(WORD_BITS);
	localparam int FRAME_W    = 12;
	localparam int CNT_W      = 13;
	localparam int WCNT_W     = CNT_W - BIT_AW;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef logic [WORD_BITS-1:0] word_t;

endpackage

FILE: rtl/bfa_ram.sv
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/bitmap_frame_allocator.sv
// first-fit page frame allocator over a bitmap of 4096 frames kept in a 128 x 32 RAM.
// alloc requests (tuser 0) for a page that holds no frame claim the lowest free frame
// among the whole 32-frame words below frames_in_use (clamped to 4096) and return it with
// present, writable and user bits; free requests (tuser 1) clear the page's frame bit.
// one request is in work at a time and s_tready is low meanwhile. an alloc scans the
// managed words (count / 32, at most 128) one word per cycle through the bitmap RAM's
// single read port; a free reads then rewrites the page's word, and an alloc for a
// backed page and a rejected free go straight to the result. the result register lets
// the next request in while a result waits. the bitmap reads as all free after reset
// through one valid flip-flop per word, so there is no clearing pass. the user must
// write frames_in_use via cfg_wr_en/cfg_wr_data only while idle; it is not enforced.
module bitmap_frame_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: frames_in_use
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // page_frame[11:0], kernel_only[12], want_write[13], zero
	input  logic        s_tuser,   // mode: 0 alloc, 1 free
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // new_frame[11:0], present[12], writable[13],
	                               // user_mode[14], updated[15]
	output logic [1:0]  m_tuser    // status
);

	import bfa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    frames_in_use_q;
	logic [NUM_WORDS-1:0] vld_q;          // word written since reset
	logic [FRAME_W-1:0]  held_q;
	logic                kern_q;
	logic                wrt_q;
	logic [WCNT_W-1:0]   scan_q;          // next word to read
	logic                pend_s1;         // a scan read is in flight
	logic [WORD_AW-1:0]  idx_s1;          // word index of the read in flight
	logic [FRAME_W-1:0]  res_frame_q;
	logic                res_pres_q;
	logic                res_wr_q;
	logic                res_usr_q;
	logic                res_upd_q;
	status_t             res_status_q;

	// request fields
	logic [FRAME_W-1:0]  in_held;
	logic                in_kern;
	logic                in_wrt;
	assign in_held = s_tdata[FRAME_W-1:0];
	assign in_kern = s_tdata[12];
	assign in_wrt  = s_tdata[13];

	// managed count, clamped to the map size
	logic [CNT_W-1:0]    count;
	logic [WCNT_W-1:0]   words;
	assign count = (frames_in_use_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frames_in_use_q;
	assign words = count[CNT_W-1:BIT_AW];

	// bitmap ram
	logic                ram_we;
	logic [WORD_AW-1:0]  ram_waddr;
	word_t               ram_wdata;
	logic [WORD_AW-1:0]  ram_raddr;
	word_t               ram_rdata;

	bfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// word just read, free until first written
	word_t               word;
	assign word = vld_q[idx_s1] ? ram_rdata : '0;

	// lowest clear bit: one-hot from a single increment, then encoded
	word_t               zero_1h;
	logic [BIT_AW-1:0]   zero_bit;
	logic                word_full;
	assign zero_1h   = ~word & (word + word_t'(1));
	assign word_full = (word == '1);

	always_comb begin
		zero_bit = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (zero_1h[i]) begin
				zero_bit = zero_bit | BIT_AW'(i);
			end
		end
	end

	logic                found;
	assign found = (state_q == S_SCAN) && pend_s1 && !word_full;

	// ram port steering: scan reads its counter, free reads the page's word
	always_comb begin
		ram_raddr = (state_q == S_FREE_RD) ? held_q[FRAME_W-1:BIT_AW] : scan_q[WORD_AW-1:0];
		ram_we    = found || (state_q == S_FREE_WR);
		ram_waddr = idx_s1;
		ram_wdata = (state_q == S_FREE_WR)
			? (word & ~(word_t'(1) << held_q[BIT_AW-1:0]))
			: (word | zero_1h);
	end

	assign s_tready = (state_q == S_IDLE);

	logic                out_free;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			frames_in_use_q <= CNT_W'(MAX_FRAMES);
			vld_q           <= '0;
			pend_s1         <= 1'b0;
			m_tvalid        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frames_in_use_q <= cfg_wr_data;
			end

			// result register drains independently of the sequencer
			if (m_tvalid && m_tready && (state_q != S_FINISH)) begin
				m_tvalid <= 1'b0;
			end

			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						held_q       <= in_held;
						kern_q       <= in_kern;
						wrt_q        <= in_wrt;
						// alloc echoes the page's frame (zero when it holds none)
						res_frame_q  <= (!s_tuser) ? in_held : '0;
						res_pres_q   <= 1'b0;
						res_wr_q     <= 1'b0;
						res_usr_q    <= 1'b0;
						res_upd_q    <= 1'b0;
						scan_q       <= '0;
						pend_s1      <= 1'b0;
						if (!s_tuser) begin
							if (in_held != '0) begin
								// page already backed: echo its frame
								res_status_q <= ST_IDLE;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (in_held == '0) begin
							res_status_q <= ST_IDLE;
							state_q      <= S_FINISH;
						end else if ({1'b0, in_held} >= count) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_FREE_RD;
						end
					end
				end
				S_SCAN: begin
					if (found) begin
						res_frame_q  <= {idx_s1, zero_bit};
						res_pres_q   <= 1'b1;
						res_wr_q     <= wrt_q;
						res_usr_q    <= ~kern_q;
						res_upd_q    <= 1'b1;
						res_status_q <= ST_DONE;
						pend_s1      <= 1'b0;
						state_q      <= S_FINISH;
					end else if (scan_q < words) begin
						pend_s1 <= 1'b1;
						idx_s1  <= scan_q[WORD_AW-1:0];
						scan_q  <= scan_q + WCNT_W'(1);
					end else if (!pend_s1) begin
						// every managed word is full
						res_status_q <= ST_EMPTY;
						state_q      <= S_FINISH;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				S_FREE_RD: begin
					idx_s1  <= held_q[FRAME_W-1:BIT_AW];
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					res_upd_q    <= 1'b1;
					res_status_q <= ST_DONE;
					state_q      <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {res_upd_q, res_usr_q, res_wr_q, res_pres_q, res_frame_q};
						m_tuser  <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/bfa_checker.sv
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [12:0] cfg_wr_data,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	import bfa_pkg::*;

	// a stalled result holds its fields
	`BFA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// the page entry is rewritten exactly on success
	`BFA_ASSERT_NOW(a_upd_done, clk, arst_n, m_tvalid,
		m_tdata[15] == (m_tuser == 2'(ST_DONE)))

	// without present the attribute bits stay clear
	`BFA_ASSERT_NOW(a_flags_clear, clk, arst_n, m_tvalid && !m_tdata[12],
		m_tdata[14:13] == 2'b00)

	// one request at a time: busy right after acceptance
	`BFA_ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

FILE: tb/tb_bitmap_frame_allocator.sv
module tb_bitmap_frame_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import bfa_pkg::*;

	// request kinds carried on s_tuser
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// cycles without any accepted transfer before the run is declared hung
	localparam int STALL_LIMIT   = 4000;
	// random requests per frame-count setting
	localparam int SEGMENT_ITEMS = 255;
	localparam int NUM_SEGMENTS  = 6;

	// one page-entry update as returned on the result side
	typedef struct packed {
		logic [FRAME_W-1:0] new_frame;
		logic               present;
		logic               writable;
		logic               user_mode;
		logic               updated;
		status_t            status;
	} entry_update_t;

	// shadow of the frame bitmap plus the page-entry updates still owed by the block
	class frame_bitmap_scoreboard;
		word_t            frame_map [NUM_WORDS];
		logic [CNT_W-1:0] frame_count;
		entry_update_t    entry_updates [$];
		int               live_frames [$];
		int               status_seen [4];
		int               requests;
		int               replies;
		int               errors;

		function new();
			foreach (frame_map[i])
				frame_map[i] = '0;
			foreach (status_seen[i])
				status_seen[i] = 0;
			frame_count = CNT_W'(MAX_FRAMES);
			requests    = 0;
			replies     = 0;
			errors      = 0;
		endfunction

		function void write_count(logic [CNT_W-1:0] value);
			frame_count = value;
		endfunction

		// counts above the bitmap size clamp to it
		function int managed_count();
			return (frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
		endfunction

		function int pending();
			return entry_updates.size();
		endfunction

		// a frame some page still holds, or -1 when none is out
		function int pick_live_frame();
			if (live_frames.size() == 0)
				return -1;
			return live_frames[$urandom_range(0, live_frames.size() - 1)];
		endfunction

		// apply one accepted request to the shadow bitmap and queue the update it owes
		function void predict_entry_update(logic mode, logic [FRAME_W-1:0] held, logic kern,
				logic wr);
			entry_update_t upd;
			int            limit;
			int            w;
			int            b;
			bit            found;
			int            hits [$];
			upd   = '0;
			limit = managed_count();
			found = 1'b0;
			if (mode == MODE_ALLOC) begin
				if (held != '0) begin
					// page already backed, echo its frame
					upd.new_frame = held;
					upd.status    = ST_IDLE;
				end else begin
					// first fit over whole words below the managed count
					for (w = 0; w < limit / WORD_BITS && !found; w++) begin
						for (b = 0; b < WORD_BITS && !found; b++) begin
							if (!frame_map[w][b]) begin
								frame_map[w][b] = 1'b1;
								upd.new_frame   = FRAME_W'(w * WORD_BITS + b);
								found           = 1'b1;
							end
						end
					end
					if (found) begin
						upd.present   = 1'b1;
						upd.writable  = wr;
						upd.user_mode = ~kern;
						upd.updated   = 1'b1;
						upd.status    = ST_DONE;
						// frame 0 reads as no frame in a page entry, so it can never come back
						if (upd.new_frame != '0)
							live_frames.push_back(int'(upd.new_frame));
					end else begin
						upd.status = ST_EMPTY;
					end
				end
			end else if (held == '0) begin
				upd.status = ST_IDLE;
			end else if (int'(held) >= limit) begin
				upd.status = ST_RANGE;
			end else begin
				frame_map[held / WORD_BITS][held % WORD_BITS] = 1'b0;
				upd.updated = 1'b1;
				upd.status  = ST_DONE;
				hits = live_frames.find_first_index(f) with (f == int'(held));
				if (hits.size() != 0)
					live_frames.delete(hits[0]);
			end
			status_seen[upd.status]++;
			requests++;
			entry_updates.push_back(upd);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_entry_update(logic [15:0] data, logic [1:0] status);
			entry_update_t want;
			if (entry_updates.size() == 0) begin
				$error("entry update with no request waiting: data %h status %0d", data, status);
				errors++;
				return;
			end
			want = entry_updates.pop_front();
			replies++;
			compare_field("new_frame", want.new_frame, data[11:0]);
			compare_field("present", want.present, data[12]);
			compare_field("writable", want.writable, data[13]);
			compare_field("user_mode", want.user_mode, data[14]);
			compare_field("updated", want.updated, data[15]);
			compare_field("status", want.status, status);
		endfunction
	endclass

	// dut ports, every input driven to a known value from time zero
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [12:0] cfg_wr_data = '0;
	logic        s_tvalid    = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata     = '0;   // page_frame[11:0], kernel_only[12], want_write[13], zero
	logic        s_tuser     = 1'b0; // mode
	logic        m_tvalid;
	logic        m_tready    = 1'b0;
	logic [15:0] m_tdata;            // new_frame[11:0], present[12], writable[13],
	                                 // user_mode[14], updated[15]
	logic [1:0]  m_tuser;            // status

	// idle percentages for each side, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_cycles  = 0;
	int count_writes  = 0;

	frame_bitmap_scoreboard sb;

	bitmap_frame_allocator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// results are checked on the pre-edge values of the handshake
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_entry_update(m_tdata, m_tuser);
	end

	// hang detection: any accepted request, result or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d updates outstanding",
				stall_cycles, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// one request, with a random lead-in gap; returns in the step it was accepted
	task automatic send_request(input logic mode, input logic [FRAME_W-1:0] frame,
			input logic kern, input logic wr);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {2'b00, wr, kern, frame};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// the shadow map moves at acceptance, so the next pick sees it
		sb.predict_entry_update(mode, frame, kern, wr);
	endtask

	// hold requests back until every owed update is out, then let the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// frames_in_use changes only with the block idle
	task automatic write_frame_count(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		sb.write_count(value);
		count_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	// mostly allocs and frees of frames really held, plus redundant and bogus requests
	task automatic send_random_request();
		int   pick;
		int   frame;
		int   top;
		logic kern;
		logic wr;
		pick = $urandom_range(0, 99);
		kern = 1'($urandom_range(0, 1));
		wr   = 1'($urandom_range(0, 1));
		top  = sb.managed_count() + 3;
		if (top > 4095)
			top = 4095;
		if (pick < 50) begin
			send_request(MODE_ALLOC, '0, kern, wr);
		end else if (pick < 60) begin
			send_request(MODE_ALLOC, FRAME_W'($urandom_range(1, 4095)), kern, wr);
		end else if (pick < 82) begin
			frame = sb.pick_live_frame();
			if (frame < 0)
				frame = $urandom_range(1, top);
			send_request(MODE_FREE, FRAME_W'(frame), kern, wr);
		end else if (pick < 88) begin
			send_request(MODE_FREE, '0, kern, wr);
		end else if (pick < 94) begin
			send_request(MODE_FREE, FRAME_W'($urandom_range(1, 4095)), kern, wr);
		end else begin
			// anywhere from frame 1 to just past the managed count
			send_request(MODE_FREE, FRAME_W'($urandom_range(1, top)), kern, wr);
		end
	endtask

	initial begin
		logic [CNT_W-1:0] segment_counts [NUM_SEGMENTS];
		segment_counts = '{13'd32, 13'd4096, 13'd47, 13'd8191, 13'd4095, 13'd64};
		sb = new();

		// reset held from time zero, released once
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset count of 4096, every flag combination on alloc
		send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);
		send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b0);
		send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1);
		send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b0);
		// alloc for a page already backed
		send_request(MODE_ALLOC, 12'd4095, 1'b1, 1'b1);
		send_request(MODE_ALLOC, 12'd1, 1'b0, 1'b0);
		// free of a page holding nothing, a real free, a free of the top frame
		send_request(MODE_FREE, 12'd0, 1'b1, 1'b1);
		send_request(MODE_FREE, 12'd1, 1'b0, 1'b1);
		send_request(MODE_FREE, 12'd4095, 1'b1, 1'b0);
		// freed frame comes back first
		send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b1);

		// smallest count: frees at and beyond it are out of range
		write_frame_count(13'd32);
		send_request(MODE_FREE, 12'd32, 1'b0, 1'b0);
		send_request(MODE_FREE, 12'd4095, 1'b0, 1'b0);
		send_request(MODE_FREE, 12'd31, 1'b0, 1'b0);
		send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);

		// count above the bitmap size clamps to 4096
		write_frame_count(13'd8191);
		send_request(MODE_FREE, 12'd4095, 1'b1, 1'b1);
		send_request(MODE_ALLOC, 12'd0, 1'b0, 1'b1);

		// count not a whole number of words: scan stops short, frees checked against it
		write_frame_count(13'd40);
		send_request(MODE_FREE, 12'd39, 1'b0, 1'b0);
		send_request(MODE_FREE, 12'd40, 1'b0, 1'b0);
		send_request(MODE_ALLOC, 12'd0, 1'b1, 1'b0);

		// random phases, idling per the phase plan, with a drain pause midway
		for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
			write_frame_count(segment_counts[seg]);
			if (seg < 2) begin
				send_idle_pct = 25;
				recv_idle_pct = 86;
			end else if (seg < 4) begin
				send_idle_pct = 86;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if (n == SEGMENT_ITEMS / 2)
					wait_drained();
				send_random_request();
			end
		end

		wait_drained();

		$display("ran %0d requests, checked %0d entry updates over %0d frame-count writes",
			sb.requests, sb.replies, count_writes);
		$display("outcomes: done %0d, nothing to do %0d, no free frame %0d, out of range %0d",
			sb.status_seen[ST_DONE], sb.status_seen[ST_IDLE], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_RANGE]);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bitmap_frame_allocator.sv
rtl/bfa_checker.sv
tb/tb_bitmap_frame_allocator.sv
